FILE: sv/cpcr_pkg.sv
// ----------------------------------------------------------------------------
// cpcr_pkg: shared types and constants for the circle pair collision resolver
// Widths of the datapath, the job record and the saturation helper.
// ----------------------------------------------------------------------------
package cpcr_pkg;

    localparam int POS_W   = 24;            // position width, signed q16.8
    localparam int DIAM_W  = 20;            // sprite diameter width
    localparam int MAG_W   = DIAM_W;        // |d| of a component when in range
    localparam int SQ_W    = 2 * MAG_W;     // one squared component
    localparam int SUM_W   = SQ_W + 1;      // dx^2 + dy^2
    localparam int EXT_W   = 8;             // extra fraction bits of the length
    localparam int RAD_W   = SQ_W + 2 * EXT_W;
    localparam int ROOT_W  = RAD_W / 2;
    localparam int REM_W   = ROOT_W + 3;
    localparam int DEP_W   = DIAM_W + EXT_W;
    localparam int PROD_W  = MAG_W + DEP_W;
    localparam int NUM_W   = PROD_W + 1;
    localparam int DVS_W   = ROOT_W + 1;
    localparam int DREM_W  = NUM_W + 1;
    localparam int Q_W     = MAG_W + 1;
    localparam int PUSH_W  = Q_W + 2;       // signed push
    localparam int WIDE_W  = POS_W + 2;     // position plus push before clamping
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = QPTR_W + 1;
    localparam logic [DIAM_W-1:0] DIAM_RESET = DIAM_W'(8192);

    // what travels with a pair through the whole datapath
    typedef struct packed {
        logic [POS_W-1:0] ax;
        logic [POS_W-1:0] ay;
        logic [POS_W-1:0] bx;
        logic [POS_W-1:0] by;
        logic             hit;
        logic             coinc;
        logic             sx;
        logic             sy;
        logic [MAG_W-1:0] mx;
        logic [MAG_W-1:0] my;
        logic [DIAM_W-1:0] dm;
    } t_ctx;

    // classified pair as queued between front and back
    typedef struct packed {
        t_ctx             ctx;
        logic [SUM_W-1:0] s;
    } t_job;

    function automatic logic [POS_W-1:0] sat_pos(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] lo;
        hi = WIDE_W'({1'b0, {(POS_W-1){1'b1}}});
        lo = -hi - WIDE_W'(1);
        if (v > hi) begin
            sat_pos = hi[POS_W-1:0];
        end else if (v < lo) begin
            sat_pos = lo[POS_W-1:0];
        end else begin
            sat_pos = v[POS_W-1:0];
        end
    endfunction

endpackage

FILE: sv/cpcr_if.sv
// ----------------------------------------------------------------------------
// cpcr_if: channel interfaces of the circle pair collision resolver
// Pair input, result output and diameter write channel.
// ----------------------------------------------------------------------------
interface cpcr_in_if import cpcr_pkg::*;;
    logic             valid;
    logic             ready;
    logic [POS_W-1:0] first_x;
    logic [POS_W-1:0] first_y;
    logic [POS_W-1:0] second_x;
    logic [POS_W-1:0] second_y;
    modport source (output valid, first_x, first_y, second_x, second_y, input ready);
    modport sink (input valid, first_x, first_y, second_x, second_y, output ready);
endinterface

interface cpcr_out_if import cpcr_pkg::*;;
    logic             valid;
    logic             ready;
    logic             hit;
    logic [POS_W-1:0] new_first_x;
    logic [POS_W-1:0] new_first_y;
    logic [POS_W-1:0] new_second_x;
    logic [POS_W-1:0] new_second_y;
    modport source (output valid, hit, new_first_x, new_first_y, new_second_x,
                    new_second_y, input ready);
    modport sink (input valid, hit, new_first_x, new_first_y, new_second_x,
                  new_second_y, output ready);
endinterface

interface cpcr_cfg_if import cpcr_pkg::*;;
    logic              valid;
    logic              ready;
    logic [DIAM_W-1:0] sprite_diameter;
    modport source (output valid, sprite_diameter, input ready);
    modport sink (input valid, sprite_diameter, output ready);
endinterface

FILE: sv/cpcr_front.sv
// ----------------------------------------------------------------------------
// cpcr_front: accept and classify stage
// Registers a pair, forms the difference, squares it and decides hit.
// ----------------------------------------------------------------------------
module cpcr_front import cpcr_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    cpcr_in_if.sink          i_pair,
    input  logic [DIAM_W-1:0] i_diam,
    input  logic             i_q_full,
    output logic             o_push,
    output t_job             o_job
);

    logic              en;
    logic              r_v1, r_v2, r_v3;
    t_ctx              r_c1, r_c2, r_c3;
    t_ctx              n_c2;
    logic              r_box2, r_box3;
    logic [SQ_W-1:0]   r_sqx, r_sqy, r_d2;

    logic signed [POS_W:0]    dx, dy;
    logic signed [POS_W+1:0]  dx_w, dy_w, dm_w;
    logic                     box;
    logic [POS_W:0]           ax_abs, ay_abs;
    logic [SUM_W-1:0]         s;

    assign en = !r_v3 || !i_q_full;
    assign i_pair.ready = en;

    // difference and box test on the registered pair
    always_comb begin
        dx     = $signed({r_c1.ax[POS_W-1], r_c1.ax}) - $signed({r_c1.bx[POS_W-1], r_c1.bx});
        dy     = $signed({r_c1.ay[POS_W-1], r_c1.ay}) - $signed({r_c1.by[POS_W-1], r_c1.by});
        dx_w   = {dx[POS_W], dx};
        dy_w   = {dy[POS_W], dy};
        dm_w   = $signed({{(POS_W+2-DIAM_W){1'b0}}, r_c1.dm});
        box    = (r_c1.dm != '0) && (dx_w < dm_w) && (dx_w > -dm_w)
                 && (dy_w < dm_w) && (dy_w > -dm_w);
        ax_abs = dx[POS_W] ? (POS_W+1)'(0) - dx : dx;
        ay_abs = dy[POS_W] ? (POS_W+1)'(0) - dy : dy;

        // second stage context: signs and magnitudes of d
        n_c2    = r_c1;
        n_c2.sx = dx[POS_W];
        n_c2.sy = dy[POS_W];
        n_c2.mx = ax_abs[MAG_W-1:0];
        n_c2.my = ay_abs[MAG_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_pair.valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c1.ax    <= i_pair.first_x;
            r_c1.ay    <= i_pair.first_y;
            r_c1.bx    <= i_pair.second_x;
            r_c1.by    <= i_pair.second_y;
            r_c1.hit   <= 1'b0;
            r_c1.coinc <= 1'b0;
            r_c1.sx    <= 1'b0;
            r_c1.sy    <= 1'b0;
            r_c1.mx    <= '0;
            r_c1.my    <= '0;
            r_c1.dm    <= i_diam;

            r_c2       <= n_c2;
            r_box2     <= box;

            r_c3       <= r_c2;
            r_box3     <= r_box2;
            r_sqx      <= r_c2.mx * r_c2.mx;
            r_sqy      <= r_c2.my * r_c2.my;
            r_d2       <= r_c2.dm * r_c2.dm;
        end
    end

    // classify: exact hit test and coincident case
    always_comb begin
        s               = {1'b0, r_sqx} + {1'b0, r_sqy};
        o_job.ctx       = r_c3;
        o_job.ctx.hit   = r_box3 && (s < {1'b0, r_d2});
        o_job.ctx.coinc = r_box3 && (s == '0);
        o_job.s         = s;
    end

    assign o_push = r_v3 && !i_q_full;

endmodule

FILE: sv/cpcr_queue.sv
// ----------------------------------------------------------------------------
// cpcr_queue: short job queue between front and back
// Register based fifo, one push and one pop per cycle.
// ----------------------------------------------------------------------------
module cpcr_queue import cpcr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    output logic o_valid,
    output t_job o_job,
    input  logic i_pop
);

    t_job              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QCNT_W-1:0] r_cnt;

    assign o_full  = r_cnt == QCNT_W'(QDEPTH);
    assign o_valid = r_cnt != '0;
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + QCNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - QCNT_W'(1);
            end
        end
    end

endmodule

FILE: sv/cpcr_back.sv
// ----------------------------------------------------------------------------
// cpcr_back: push datapath
// Pipelined square root, depth, multiply, pipelined divide and clamping.
// ----------------------------------------------------------------------------
module cpcr_back import cpcr_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_q_valid,
    input  t_job     i_q_job,
    output logic     o_q_pop,
    cpcr_out_if.source o_res
);

    localparam int SQ_N = ROOT_W;
    localparam int DV_N = Q_W;

    logic en;
    logic r_out_valid;

    // square root pipe, index 0 is the entry register
    logic              r_sq_v    [SQ_N+1];
    t_ctx              r_sq_ctx  [SQ_N+1];
    logic [RAD_W-1:0]  r_sq_rad  [SQ_N+1];
    logic [REM_W-1:0]  r_sq_rem  [SQ_N+1];
    logic [ROOT_W-1:0] r_sq_root [SQ_N+1];

    // depth, product and numerator stages
    logic              r_a_v, r_m_v;
    t_ctx              r_a_ctx, r_m_ctx;
    logic [ROOT_W-1:0] r_a_lq, r_m_lq;
    logic [DEP_W-1:0]  r_a_depth;
    logic [PROD_W-1:0] r_m_px, r_m_py;

    // divide pipe, index 0 holds the numerators
    logic              r_dv_v   [DV_N+1];
    t_ctx              r_dv_ctx [DV_N+1];
    logic [DVS_W-1:0]  r_dv_dvs [DV_N+1];
    logic [DREM_W-1:0] r_dv_rx  [DV_N+1];
    logic [DREM_W-1:0] r_dv_ry  [DV_N+1];
    logic [Q_W-1:0]    r_dv_qx  [DV_N+1];
    logic [Q_W-1:0]    r_dv_qy  [DV_N+1];

    assign en      = !r_out_valid || o_res.ready;
    assign o_q_pop = en && i_q_valid;

    // entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_v[0] <= 1'b0;
        end else if (en) begin
            r_sq_v[0] <= i_q_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sq_ctx[0]  <= i_q_job.ctx;
            r_sq_rad[0]  <= i_q_job.ctx.hit ? {i_q_job.s[SQ_W-1:0], {(2*EXT_W){1'b0}}} : '0;
            r_sq_rem[0]  <= '0;
            r_sq_root[0] <= '0;
        end
    end

    // one root bit per stage
    for (genvar j = 1; j <= SQ_N; j++) begin : g_sqrt
        logic [REM_W-1:0] remsh;
        logic [REM_W-1:0] trial;
        logic             ge;

        always_comb begin
            remsh = {r_sq_rem[j-1][REM_W-3:0], r_sq_rad[j-1][RAD_W-1 -: 2]};
            trial = {{(REM_W-ROOT_W-2){1'b0}}, r_sq_root[j-1], 2'b01};
            ge    = remsh >= trial;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_v[j] <= 1'b0;
            end else if (en) begin
                r_sq_v[j] <= r_sq_v[j-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sq_ctx[j]  <= r_sq_ctx[j-1];
                r_sq_rad[j]  <= {r_sq_rad[j-1][RAD_W-3:0], 2'b00};
                r_sq_rem[j]  <= ge ? remsh - trial : remsh;
                r_sq_root[j] <= {r_sq_root[j-1][ROOT_W-2:0], ge};
            end
        end
    end

    // depth, then products, then numerators with rounding term
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v     <= 1'b0;
            r_m_v     <= 1'b0;
            r_dv_v[0] <= 1'b0;
        end else if (en) begin
            r_a_v     <= r_sq_v[SQ_N];
            r_m_v     <= r_a_v;
            r_dv_v[0] <= r_m_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_ctx     <= r_sq_ctx[SQ_N];
            r_a_lq      <= r_sq_root[SQ_N];
            r_a_depth   <= {r_sq_ctx[SQ_N].dm, {EXT_W{1'b0}}} - r_sq_root[SQ_N];

            r_m_ctx     <= r_a_ctx;
            r_m_lq      <= r_a_lq;
            r_m_px      <= r_a_ctx.mx * r_a_depth;
            r_m_py      <= r_a_ctx.my * r_a_depth;

            r_dv_ctx[0] <= r_m_ctx;
            r_dv_dvs[0] <= {r_m_lq, 1'b0};
            r_dv_rx[0]  <= {2'b00, r_m_px} + {{(DREM_W-ROOT_W){1'b0}}, r_m_lq};
            r_dv_ry[0]  <= {2'b00, r_m_py} + {{(DREM_W-ROOT_W){1'b0}}, r_m_lq};
            r_dv_qx[0]  <= '0;
            r_dv_qy[0]  <= '0;
        end
    end

    // one quotient bit per stage, msb first
    for (genvar j = 1; j <= DV_N; j++) begin : g_div
        logic [DREM_W-1:0] sd;
        logic              gex, gey;

        always_comb begin
            sd  = {{(DREM_W-DVS_W){1'b0}}, r_dv_dvs[j-1]} << (DV_N - j);
            gex = r_dv_rx[j-1] >= sd;
            gey = r_dv_ry[j-1] >= sd;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_v[j] <= 1'b0;
            end else if (en) begin
                r_dv_v[j] <= r_dv_v[j-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dv_ctx[j] <= r_dv_ctx[j-1];
                r_dv_dvs[j] <= r_dv_dvs[j-1];
                r_dv_rx[j]  <= gex ? r_dv_rx[j-1] - sd : r_dv_rx[j-1];
                r_dv_ry[j]  <= gey ? r_dv_ry[j-1] - sd : r_dv_ry[j-1];
                r_dv_qx[j]  <= {r_dv_qx[j-1][Q_W-2:0], gex};
                r_dv_qy[j]  <= {r_dv_qy[j-1][Q_W-2:0], gey};
            end
        end
    end

    // push selection and clamping into the output register
    t_ctx                     fc;
    logic [Q_W-1:0]           half_dm, magx, magy;
    logic signed [PUSH_W-1:0] px, py;
    logic signed [WIDE_W-1:0] wax, way, wbx, wby, wpx, wpy;

    always_comb begin
        fc      = r_dv_ctx[DV_N];
        half_dm = Q_W'(({1'b0, fc.dm} + (DIAM_W+1)'(1)) >> 1);
        magx    = fc.coinc ? half_dm : r_dv_qx[DV_N];
        magy    = fc.coinc ? '0 : r_dv_qy[DV_N];
        px      = !fc.hit ? '0 : (fc.sx ? -$signed({2'b00, magx}) : $signed({2'b00, magx}));
        py      = !fc.hit ? '0 : (fc.sy ? -$signed({2'b00, magy}) : $signed({2'b00, magy}));
        wax     = $signed({{2{fc.ax[POS_W-1]}}, fc.ax});
        way     = $signed({{2{fc.ay[POS_W-1]}}, fc.ay});
        wbx     = $signed({{2{fc.bx[POS_W-1]}}, fc.bx});
        wby     = $signed({{2{fc.by[POS_W-1]}}, fc.by});
        wpx     = $signed({{(WIDE_W-PUSH_W){px[PUSH_W-1]}}, px});
        wpy     = $signed({{(WIDE_W-PUSH_W){py[PUSH_W-1]}}, py});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_dv_v[DV_N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_res.hit          <= fc.hit;
            o_res.new_first_x  <= sat_pos(wax + wpx);
            o_res.new_first_y  <= sat_pos(way + wpy);
            o_res.new_second_x <= sat_pos(wbx - wpx);
            o_res.new_second_y <= sat_pos(wby - wpy);
        end
    end

    assign o_res.valid = r_out_valid;

    a_depth_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_v && r_a_ctx.hit |-> r_a_depth != '0)
        else $error("non-positive depth on a hit");

    a_coinc_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_v && r_a_ctx.coinc |-> r_a_lq == '0)
        else $error("coincident pair with non-zero length");

    a_quot_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dv_v[DV_N] && fc.hit && !fc.coinc |-> !r_dv_qx[DV_N][Q_W-1] && !r_dv_qy[DV_N][Q_W-1])
        else $error("push quotient out of range");

endmodule

FILE: sv/circle_pair_collision_resolve.sv
// throughput: one pair per cycle while the receiver takes every result
// the back holds a 28-stage root pipe and a 21-stage divide pipe
// front and back stall on their own; the 4-deep queue soaks up back-pressure
// reset (synchronous, active low) empties every stage and the queue
// the diameter register comes out of reset at 8192 (32.0 in q12.8)
// ----------------------------------------------------------------------------
// circle_pair_collision_resolve: separate two overlapping circular sprites
// Classifies a pair, then pushes both corners apart along their difference.
// ----------------------------------------------------------------------------
module circle_pair_collision_resolve import cpcr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cpcr_in_if.sink    i_pair,
    cpcr_cfg_if.sink   i_cfg,
    cpcr_out_if.source o_res
);

    // diameter register, written one beat at a time, always ready
    logic [DIAM_W-1:0] r_diam;

    logic q_full, q_push, q_valid, q_pop;
    t_job push_job, head_job;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_diam <= DIAM_RESET;
        end else if (i_cfg.valid) begin
            r_diam <= i_cfg.sprite_diameter;
        end
    end

    // front: capture the pair, form d, square it, decide hit and coincidence
    cpcr_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_pair   (i_pair),
        .i_diam   (r_diam),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_job    (push_job)
    );

    // queue: decouples the front's accept from the back's output stall
    cpcr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (push_job),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (head_job),
        .i_pop   (q_pop)
    );

    // back: length by root pipe, depth, scaled push by divide pipe, clamp
    cpcr_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_job   (head_job),
        .o_q_pop   (q_pop),
        .o_res     (o_res)
    );

endmodule

FILE: sim/tb_circle_pair_collision_resolve.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_circle_pair_collision_resolve: self-checking bench for the pair resolver
// Drives sprite pairs with random gaps, predicts each resolved pair in
// fixed point and compares each result beat with the prediction in all fields.
// ----------------------------------------------------------------------------
module tb_circle_pair_collision_resolve;
    import cpcr_pkg::*;

    typedef struct packed {
        logic             hit;
        logic [POS_W-1:0] fx;
        logic [POS_W-1:0] fy;
        logic [POS_W-1:0] sx;
        logic [POS_W-1:0] sy;
    } t_resolved;

    logic i_clk;
    logic i_rst_n;

    cpcr_in_if  pair_ch ();
    cpcr_cfg_if cfg_ch ();
    cpcr_out_if res_ch ();

    circle_pair_collision_resolve uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pair  (pair_ch.sink),
        .i_cfg   (cfg_ch.sink),
        .o_res   (res_ch.source)
    );

    t_resolved          resolved_q[$];
    logic [DIAM_W-1:0]  diameter;
    int                 mismatches;
    int                 cycle_cnt;
    int                 hold_off;     // long receiver stall, in cycles
    int                 sink_wait;    // cycles left before the receiver takes the next beat
    bit                 idle_sink;    // receiver stalls only during a hold-off when set

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // overall limit on run length
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > 400000) begin
            $display("tb_circle_pair_collision_resolve NOT OK");
            $finish;
        end
    end

    // integer square root, bit by bit
    function automatic longint unsigned root_of(input longint unsigned x);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= res + b) begin
                x = x - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic longint push_along(input longint dc, input longint unsigned depth,
                                          input longint unsigned len);
        longint unsigned mag;
        longint unsigned p;
        mag = (dc < 0) ? -dc : dc;
        p = (mag * depth + len) / (2 * len);
        return (dc < 0) ? -longint'(p) : longint'(p);
    endfunction

    function automatic logic [POS_W-1:0] clamp_pos(input longint v);
        longint hi;
        hi = (64'sd1 <<< (POS_W - 1)) - 1;
        if (v > hi) v = hi;
        if (v < -hi - 1) v = -hi - 1;
        return v[POS_W-1:0];
    endfunction

    // expected resolution of one pair under the current diameter
    function automatic t_resolved resolve_pair(input logic [POS_W-1:0] ax_i,
            input logic [POS_W-1:0] ay_i, input logic [POS_W-1:0] bx_i,
            input logic [POS_W-1:0] by_i);
        t_resolved r;
        longint ax, ay, bx, by, dx, dy, dm, px, py;
        longint unsigned s, len, depth;
        ax = longint'(signed'(ax_i));
        ay = longint'(signed'(ay_i));
        bx = longint'(signed'(bx_i));
        by = longint'(signed'(by_i));
        dx = ax - bx;
        dy = ay - by;
        dm = longint'(diameter);
        px = 0;
        py = 0;
        r.hit = 1'b0;
        if (dm > 0 && dx > -dm && dx < dm && dy > -dm && dy < dm) begin
            s = dx * dx + dy * dy;
            if (s < dm * dm) begin
                r.hit = 1'b1;
                if (s == 0) begin
                    // coincident corners: push along +x by half the diameter
                    px = (dm + 1) >>> 1;
                end else begin
                    len = root_of(s << (2 * EXT_W));
                    depth = (longint'(dm) << EXT_W) - len;
                    px = push_along(dx, depth, len);
                    py = push_along(dy, depth, len);
                end
            end
        end
        r.fx = clamp_pos(ax + px);
        r.fy = clamp_pos(ay + py);
        r.sx = clamp_pos(bx - px);
        r.sy = clamp_pos(by - py);
        return r;
    endfunction

    // one pair beat, with a random gap in front of it
    task automatic send_pair(input logic [POS_W-1:0] ax, input logic [POS_W-1:0] ay,
                             input logic [POS_W-1:0] bx, input logic [POS_W-1:0] by,
                             input bit gaps = 1'b1);
        int gap;
        gap = gaps ? $urandom_range(0, 12) : 0;
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            pair_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pair_ch.valid    <= 1'b1;
        pair_ch.first_x  <= ax;
        pair_ch.first_y  <= ay;
        pair_ch.second_x <= bx;
        pair_ch.second_y <= by;
        @(posedge i_clk);
        while (!pair_ch.ready) @(posedge i_clk);
        resolved_q = {resolved_q, resolve_pair(ax, ay, bx, by)};
    endtask

    task automatic end_pairs();
        pair_ch.valid <= 1'b0;
    endtask

    task automatic drain();
        end_pairs();
        while (resolved_q.size() != 0) @(posedge i_clk);
        repeat (70) @(posedge i_clk);
    endtask

    task automatic write_diameter(input logic [DIAM_W-1:0] v);
        cfg_ch.valid           <= 1'b1;
        cfg_ch.sprite_diameter <= v;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        diameter = v;
    endtask

    // receiver: a drawn wait before each beat, always ready when idle_sink is set, or a long hold-off when asked
    always @(posedge i_clk) begin
        int w;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            sink_wait    <= 0;
        end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            res_ch.ready <= 1'b0;
        end else if (idle_sink) begin
            res_ch.ready <= 1'b1;
        end else if (res_ch.valid && res_ch.ready) begin
            // beat taken: draw the wait for the next one
            w = $urandom_range(0, 12);
            sink_wait    <= w;
            res_ch.ready <= (w == 0);
        end else if (sink_wait > 0) begin
            sink_wait    <= sink_wait - 1;
            res_ch.ready <= (sink_wait == 1);
        end else begin
            res_ch.ready <= 1'b1;
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_resolved want;
        t_resolved got;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            got = '{res_ch.hit, res_ch.new_first_x, res_ch.new_first_y,
                    res_ch.new_second_x, res_ch.new_second_y};
            if (resolved_q.size() == 0) begin
                mismatches = mismatches + 1;
                if (mismatches <= 10) $display("unexpected result beat %p", got);
            end else begin
                want = resolved_q.pop_front();
                if (got !== want) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p actual %p", want, got);
                end
            end
        end
    end

    function automatic logic [POS_W-1:0] rand_pos();
        return POS_W'($urandom);
    endfunction

    // corner pair near each other relative to the diameter
    task automatic send_close_pair(input bit gaps = 1'b1);
        logic [POS_W-1:0] ax, ay;
        int span;
        ax = rand_pos();
        ay = rand_pos();
        span = (diameter == 0) ? 4 : int'(diameter) + 4;
        send_pair(ax, ay, ax + POS_W'($urandom_range(0, 2 * span) - span),
                  ay + POS_W'($urandom_range(0, 2 * span) - span), gaps);
    endtask

    task automatic test_extremes();
        logic [POS_W-1:0] mx, mn;
        mx = {1'b0, {(POS_W-1){1'b1}}};
        mn = {1'b1, {(POS_W-1){1'b0}}};
        send_pair(0, 0, 0, 0);                  // coincident corners
        send_pair(mx, mx, mx, mx);              // coincident, saturating
        send_pair(mn, mn, mn, mn);
        send_pair(mx, 0, mx - POS_W'(100), 0);  // first pushed past the top
        send_pair(mn, 0, mn + POS_W'(100), 0);
        send_pair(0, 0, 8192, 0);               // touching exactly, no hit
        send_pair(0, 0, 8191, 0);
        send_pair(0, 0, 0, POS_W'(-8191));
        send_pair(100, 200, 103, 196);
        send_pair(mx, mx, mn, mn);              // far apart
        send_pair(mn, mx, mx, mn);
        send_pair(24'h555555, 24'haaaaaa, 24'haaaaaa, 24'h555555);
        drain();
    endtask

    task automatic test_diameters();
        write_diameter(0);                      // zero diameter never hits
        send_pair(0, 0, 0, 0);
        send_pair(5, 5, 4, 4);
        drain();
        write_diameter({DIAM_W{1'b1}});         // largest diameter
        send_pair(0, 0, 0, 0);
        send_pair(0, 0, 24'hf00001, 24'h0fffff);
        send_pair(24'h7fffff, 0, 24'h700000, 0);
        send_pair(0, 0, 1, 1);
        drain();
        write_diameter(1);
        send_pair(0, 0, 0, 0);
        send_pair(0, 0, 1, 0);
        drain();
    endtask

    task automatic test_random(input int n);
        int k;
        logic [DIAM_W-1:0] d;
        for (k = 0; k < n; k++) begin
            if (k % 150 == 0) begin
                drain();
                case ($urandom_range(0, 3))
                    0: d = DIAM_W'($urandom);
                    1: d = DIAM_W'($urandom_range(1, 64));
                    2: d = DIAM_W'($urandom_range(1000, 20000));
                    default: d = {DIAM_W{1'b1}} - DIAM_W'($urandom_range(0, 3));
                endcase
                write_diameter(d);
            end
            if ($urandom_range(0, 9) < 8) send_close_pair();
            else send_pair(rand_pos(), rand_pos(), rand_pos(), rand_pos());
        end
        drain();
    endtask

    // long receiver stall with the sender streaming, then a paused sender
    task automatic test_backpressure();
        int k;
        idle_sink = 1'b0;
        hold_off = 200;
        for (k = 0; k < 100; k++) send_close_pair(1'b0);
        drain();
        idle_sink = 1'b1;
        for (k = 0; k < 100; k++) send_close_pair(1'b0);
        end_pairs();
        while (resolved_q.size() != 0) @(posedge i_clk);
        for (k = 0; k < 30; k++) send_close_pair();
        drain();
        idle_sink = 1'b0;
    endtask

    initial begin
        i_rst_n               = 1'b0;
        cycle_cnt             = 0;
        mismatches            = 0;
        hold_off              = 0;
        idle_sink             = 1'b0;
        diameter              = DIAM_RESET;
        pair_ch.valid         = 1'b0;
        pair_ch.first_x       = '0;
        pair_ch.first_y       = '0;
        pair_ch.second_x      = '0;
        pair_ch.second_y      = '0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.sprite_diameter = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_extremes();
        test_diameters();
        test_backpressure();
        test_random(850);

        if (mismatches == 0) begin
            $display("tb_circle_pair_collision_resolve OK");
        end else begin
            $display("tb_circle_pair_collision_resolve NOT OK");
        end
        $finish;
    end

endmodule

FILE: circle_pair_collision_resolve.f
sv/cpcr_pkg.sv
sv/cpcr_if.sv
sv/cpcr_front.sv
sv/cpcr_queue.sv
sv/cpcr_back.sv
sv/circle_pair_collision_resolve.sv
sim/tb_circle_pair_collision_resolve.sv
